/* hw/rtl/gbpf_pkg.sv */
// Shared constants, field layout, operation codes and control types for the page frame store.
package gbpf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int MAX_GLYPH      = 64;

    localparam int BYTE_BITS   = 8;
    localparam int PAGE_ROWS   = 8;
    localparam int PAGE_SHIFT  = $clog2(PAGE_ROWS);
    localparam int PAGES       = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int MAX_DIM     = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
    localparam int COORD_W     = $clog2(MAX_DIM);

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 16;
    localparam int POS_EXT_W  = POS_W + 2;
    localparam int COLOUR_W   = 2;
    localparam int GSIZE_W    = 7;
    localparam int RADDR_IN_W = 10;
    localparam int KIDX_W     = $clog2(BYTE_BITS);
    localparam int NCNT_W     = KIDX_W + 1;

    // s_tdata layout, lowest bits first.
    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = POS_X_LSB + POS_W;
    localparam int COLOUR_LSB  = POS_Y_LSB + POS_W;
    localparam int BG_LSB      = COLOUR_LSB + COLOUR_W;
    localparam int GW_LSB      = BG_LSB + COLOUR_W;
    localparam int GH_LSB      = GW_LSB + GSIZE_W;
    localparam int BITMAP_LSB  = GH_LSB + GSIZE_W;
    localparam int RADDR_LSB   = BITMAP_LSB + BYTE_BITS;
    localparam int S_DATA_BITS = RADDR_LSB + RADDR_IN_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;

    // s_tuser layout, lowest bits first.
    localparam int FUNC_LSB   = 0;
    localparam int START_LSB  = FUNC_LSB + FUNC_W;
    localparam int S_TUSER_W  = START_LSB + 1;

    localparam int M_TDATA_W = BYTE_BITS;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;
    localparam int ROTATION_W   = 2;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION = '0;

    localparam logic [FUNC_W-1:0] FUNC_PLOT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GLYPH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    localparam logic [COLOUR_W-1:0] COL_CLEAR  = 2'd0;
    localparam logic [COLOUR_W-1:0] COL_SET    = 2'd1;
    localparam logic [COLOUR_W-1:0] COL_INVERT = 2'd2;
    localparam logic [COLOUR_W-1:0] COL_KEEP   = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic pix_rd;
        logic pix_wr;
        logic rd_mem;
        logic finish;
    } gbpf_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pix_none;
        logic              pix_last;
        logic              clr_last;
        logic              out_busy;
    } gbpf_stat_t;

endpackage

/* hw/rtl/gbpf_ctrl.sv */
// Controller state machine that sequences clears, pixel read-modify-writes and reads.
module gbpf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gbpf_pkg::gbpf_stat_t stat,
    output gbpf_pkg::gbpf_cmd_t  cmd
);
    import gbpf_pkg::*;

    localparam logic [2:0] ST_BOOT     = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_PIX_RD   = 3'd3;
    localparam logic [2:0] ST_PIX_WR   = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;
    localparam logic [2:0] ST_CLEAR    = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_BOOT: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.func)
                    FUNC_PLOT, FUNC_GLYPH: begin
                        state_next = stat.pix_none ? ST_FINISH : ST_PIX_RD;
                    end
                    FUNC_CLEAR: begin
                        state_next = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_READ;
                    end
                endcase
            end
            ST_PIX_RD: begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                cmd.pix_wr = 1'b1;
                state_next = stat.pix_last ? ST_FINISH : ST_PIX_RD;
            end
            ST_READ: begin
                cmd.rd_mem = 1'b1;
                state_next = ST_FINISH;
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/gbpf_dpath.sv */
// Datapath with the frame store, glyph cursor, pixel address unit and result register.
module gbpf_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gbpf_pkg::gbpf_cmd_t                 cmd,
    output gbpf_pkg::gbpf_stat_t                stat,
    input  logic [gbpf_pkg::ROTATION_W-1:0]     rotation,
    input  logic [gbpf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [gbpf_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [gbpf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import gbpf_pkg::*;

    localparam int RC_W = GSIZE_W + 1;

    logic [BYTE_BITS-1:0] mem [STORE_BYTES];

    logic [FUNC_W-1:0]           in_func;
    logic                        in_start;
    logic signed [POS_W-1:0]     in_x;
    logic signed [POS_W-1:0]     in_y;
    logic [COLOUR_W-1:0]         in_fg;
    logic [COLOUR_W-1:0]         in_bg;
    logic [GSIZE_W-1:0]          in_w;
    logic [GSIZE_W-1:0]          in_h;
    logic [BYTE_BITS-1:0]        in_bits;
    logic [RADDR_IN_W-1:0]       in_raddr;

    logic [FUNC_W-1:0]           func_reg;
    logic signed [POS_EXT_W-1:0] xbase_reg;
    logic signed [POS_EXT_W-1:0] ybase_reg;
    logic [COLOUR_W-1:0]         fg_reg;
    logic [COLOUR_W-1:0]         bg_reg;
    logic [BYTE_BITS-1:0]        bits_reg;
    logic [NCNT_W-1:0]           n_reg;
    logic [KIDX_W-1:0]           k_reg;
    logic [RADDR_IN_W-1:0]       raddr_reg;
    logic                        done_reg;
    logic [GSIZE_W-1:0]          glyph_row_reg;
    logic [GSIZE_W-1:0]          glyph_col_reg;
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic [BYTE_BITS-1:0]        mask_reg;
    logic [COLOUR_W-1:0]         op_reg;
    logic                        wen_reg;
    logic [BYTE_BITS-1:0]        rdata_reg;
    logic                        out_valid_reg;
    logic [M_TDATA_W-1:0]        out_data_reg;
    logic                        out_last_reg;

    logic [GSIZE_W-1:0]          wc, hc, r0, c0, c1, rem;
    logic [RC_W-1:0]             r1, r2, c2;
    logic                        empty, over;
    logic [NCNT_W-1:0]           gn;
    logic signed [POS_EXT_W-1:0] xsext, ysext;
    logic [NCNT_W-1:0]           n_load;
    logic                        done_load;
    logic signed [POS_EXT_W-1:0] xbase_load, ybase_load;
    logic [GSIZE_W-1:0]          row_load, col_load;

    logic signed [POS_EXT_W-1:0] px_l, kx, lw, lh;
    logic [COORD_W-1:0]          lx, ly, phx, phy;
    logic                        on_screen, pix_bit, draw;
    logic [COLOUR_W-1:0]         sel;
    logic [ADDR_W-1:0]           pix_addr;
    logic [BYTE_BITS-1:0]        pix_mask;

    logic [ADDR_W-1:0]           mem_addr;
    logic                        mem_we;
    logic                        mem_re;
    logic [BYTE_BITS-1:0]        modified;
    logic [BYTE_BITS-1:0]        mem_wdata;
    logic                        read_in_range;

    assign in_func  = s_tuser[FUNC_LSB +: FUNC_W];
    assign in_start = s_tuser[START_LSB];
    assign in_x     = s_tdata[POS_X_LSB +: POS_W];
    assign in_y     = s_tdata[POS_Y_LSB +: POS_W];
    assign in_fg    = s_tdata[COLOUR_LSB +: COLOUR_W];
    assign in_bg    = s_tdata[BG_LSB +: COLOUR_W];
    assign in_w     = s_tdata[GW_LSB +: GSIZE_W];
    assign in_h     = s_tdata[GH_LSB +: GSIZE_W];
    assign in_bits  = s_tdata[BITMAP_LSB +: BYTE_BITS];
    assign in_raddr = s_tdata[RADDR_LSB +: RADDR_IN_W];

    // Glyph cursor bookkeeping for the incoming transaction.
    always_comb begin
        wc    = (in_w > GSIZE_W'(MAX_GLYPH)) ? GSIZE_W'(MAX_GLYPH) : in_w;
        hc    = (in_h > GSIZE_W'(MAX_GLYPH)) ? GSIZE_W'(MAX_GLYPH) : in_h;
        r0    = in_start ? '0 : glyph_row_reg;
        c0    = in_start ? '0 : glyph_col_reg;
        empty = (wc == '0) || (hc == '0);
        if (c0 >= wc) begin
            c1 = '0;
            r1 = {1'b0, r0} + RC_W'(1);
        end else begin
            c1 = c0;
            r1 = {1'b0, r0};
        end
        over  = r1 >= {1'b0, hc};
        rem   = wc - c1;
        gn    = (rem > GSIZE_W'(BYTE_BITS)) ? NCNT_W'(BYTE_BITS) : NCNT_W'(rem);
        c2    = {1'b0, c1} + RC_W'(gn);
        r2    = r1 + RC_W'(1);
        xsext = POS_EXT_W'(in_x);
        ysext = POS_EXT_W'(in_y);

        n_load     = '0;
        done_load  = 1'b0;
        xbase_load = xsext;
        ybase_load = ysext;
        row_load   = glyph_row_reg;
        col_load   = glyph_col_reg;
        case (in_func)
            FUNC_PLOT: begin
                n_load = NCNT_W'(1);
            end
            FUNC_GLYPH: begin
                if (empty || over) begin
                    done_load = 1'b1;
                    row_load  = '0;
                    col_load  = '0;
                end else begin
                    n_load     = gn;
                    xbase_load = xsext + POS_EXT_W'(c1);
                    ybase_load = ysext + POS_EXT_W'(r1);
                    if (c2 >= {1'b0, wc}) begin
                        col_load = '0;
                        if (r2 >= {1'b0, hc}) begin
                            row_load  = '0;
                            done_load = 1'b1;
                        end else begin
                            row_load = GSIZE_W'(r2);
                        end
                    end else begin
                        col_load = GSIZE_W'(c2);
                        row_load = GSIZE_W'(r1);
                    end
                end
            end
            default: begin
                n_load = '0;
            end
        endcase
    end

    // Pixel clipping, rotation and addressing for pixel k of the current transaction.
    always_comb begin
        kx        = POS_EXT_W'(k_reg);
        px_l      = xbase_reg + kx;
        lw        = rotation[0] ? POS_EXT_W'(DISPLAY_HEIGHT) : POS_EXT_W'(DISPLAY_WIDTH);
        lh        = rotation[0] ? POS_EXT_W'(DISPLAY_WIDTH) : POS_EXT_W'(DISPLAY_HEIGHT);
        on_screen = !px_l[POS_EXT_W-1] && (px_l < lw) && !ybase_reg[POS_EXT_W-1] && (ybase_reg < lh);
        lx        = px_l[COORD_W-1:0];
        ly        = ybase_reg[COORD_W-1:0];
        case (rotation)
            2'd1: begin
                phx = COORD_W'(DISPLAY_WIDTH - 1) - ly;
                phy = lx;
            end
            2'd2: begin
                phx = COORD_W'(DISPLAY_WIDTH - 1) - lx;
                phy = COORD_W'(DISPLAY_HEIGHT - 1) - ly;
            end
            2'd3: begin
                phx = ly;
                phy = COORD_W'(DISPLAY_HEIGHT - 1) - lx;
            end
            default: begin
                phx = lx;
                phy = ly;
            end
        endcase
        pix_addr = ADDR_W'(phx) + ADDR_W'(phy >> PAGE_SHIFT) * ADDR_W'(DISPLAY_WIDTH);
        pix_mask = BYTE_BITS'(1) << phy[PAGE_SHIFT-1:0];
        pix_bit  = bits_reg[KIDX_W'(BYTE_BITS - 1) - k_reg];
        sel      = pix_bit ? fg_reg : bg_reg;
        draw     = on_screen && (pix_bit || (bg_reg != fg_reg)) && (sel != COL_KEEP);
    end

    always_comb begin
        case (op_reg)
            COL_CLEAR:  modified = rdata_reg & ~mask_reg;
            COL_SET:    modified = rdata_reg | mask_reg;
            COL_INVERT: modified = rdata_reg ^ mask_reg;
            default:    modified = rdata_reg;
        endcase
    end

    always_comb begin
        if (cmd.clr_step) begin
            mem_addr = clr_cnt_reg;
        end else if (cmd.pix_wr) begin
            mem_addr = addr_reg;
        end else if (cmd.pix_rd) begin
            mem_addr = pix_addr;
        end else begin
            mem_addr = ADDR_W'(raddr_reg);
        end
    end

    assign mem_we        = cmd.clr_step || (cmd.pix_wr && wen_reg);
    assign mem_re        = cmd.pix_rd || cmd.rd_mem;
    assign mem_wdata     = cmd.clr_step ? '0 : modified;
    assign read_in_range = 32'(raddr_reg) < STORE_BYTES;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= in_func;
            xbase_reg <= xbase_load;
            ybase_reg <= ybase_load;
            fg_reg    <= in_fg;
            bg_reg    <= in_bg;
            bits_reg  <= (in_func == FUNC_PLOT) ? BYTE_BITS'(1) << (BYTE_BITS - 1) : in_bits;
            n_reg     <= n_load;
            k_reg     <= '0;
            raddr_reg <= in_raddr;
            done_reg  <= done_load;
        end else if (cmd.pix_wr) begin
            k_reg <= k_reg + KIDX_W'(1);
        end
        if (cmd.pix_rd) begin
            addr_reg <= pix_addr;
            mask_reg <= pix_mask;
            op_reg   <= sel;
            wen_reg  <= draw;
        end
        if (cmd.finish) begin
            out_data_reg <= ((func_reg == FUNC_READ) && read_in_range) ? rdata_reg : '0;
            out_last_reg <= done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_row_reg <= '0;
            glyph_col_reg <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                glyph_row_reg <= row_load;
                glyph_col_reg <= col_load;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.func     = func_reg;
    assign stat.pix_none = (n_reg == '0);
    assign stat.pix_last = (NCNT_W'(k_reg) + NCNT_W'(1)) == n_reg;
    assign stat.clr_last = (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/glyph_blit_page_framebuffer_top.sv */
// Top level of the page-organized frame store with pixel plot, glyph blit, clear and read.
//
// Each transaction is handled on its own: a pixel plot reads and writes one pixel, a glyph
// bitmap byte steps through the n pixels of its row span, drawn or not (at most 8), a byte
// read reads one byte and a store clear writes every byte of the store.
// Every pixel is a read followed by a write of the single-port frame store. After reset the
// whole store of 1024 bytes is cleared with s_tready low; configuration writes are taken
// throughout. A finished result waits in an output register, so the next transaction can be
// accepted while it is held.
module glyph_blit_page_framebuffer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: pos_x, pos_y, colour, bg_colour, glyph_width, glyph_height,
    // bitmap_byte, read_addr, then zero padding.
    input  logic [gbpf_pkg::S_TDATA_W-1:0]      s_tdata,
    // Fields from bit 0: func, glyph_start.
    input  logic [gbpf_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: read_data.
    output logic [gbpf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbpf_pkg::PADDR_W-1:0]        paddr,
    input  logic [gbpf_pkg::PDATA_W-1:0]        pwdata,
    output logic [gbpf_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import gbpf_pkg::*;

    logic [ROTATION_W-1:0] rotation_reg;
    logic                  rot_sel;
    gbpf_cmd_t             cmd;
    gbpf_stat_t            stat;

    assign pready  = 1'b1;
    assign rot_sel = (paddr[PADDR_W-1:2] == REG_ROTATION);
    assign prdata  = rot_sel ? PDATA_W'(rotation_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= '0;
        end else if (psel && penable && pwrite && pready && rot_sel) begin
            rotation_reg <= pwdata[ROTATION_W-1:0];
        end
    end

    gbpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbpf_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .rotation (rotation_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/gbpf_checker.sv */
// Port-level checker for the frame store top level, bound to it below.
module gbpf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gbpf_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tlast
);
    import gbpf_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_tvalid && s_tready) begin
            pending_next = pending_next + 2'd1;
        end
        if (m_tvalid && m_tready) begin
            pending_next = pending_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result transaction changed.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("Channels active right after reset.");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("Result transaction without an accepted input transaction.");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 |-> !s_tready)
        else $error("Input accepted with a result waiting and another in progress.");

endmodule

bind glyph_blit_page_framebuffer_top gbpf_checker u_gbpf_checker (.*);

/* tb/tb_glyph_blit_page_framebuffer_top.sv */
// Self-checking testbench for the page frame store: directed table, random phases, predictor.
module tb_glyph_blit_page_framebuffer_top;
    import gbpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [PADDR_W-1:0] ROT_ADDR = {REG_ROTATION, 2'b00};

    typedef struct {
        bit [FUNC_W-1:0]     func;
        bit signed [POS_W-1:0] pos_x;
        bit signed [POS_W-1:0] pos_y;
        bit [COLOUR_W-1:0]   colour;
        bit [COLOUR_W-1:0]   bg_colour;
        bit [GSIZE_W-1:0]    gw;
        bit [GSIZE_W-1:0]    gh;
        bit [BYTE_BITS-1:0]  bitmap;
        bit                  start;
        bit [RADDR_IN_W-1:0] raddr;
    } blit_txn_t;

    typedef struct {
        bit [BYTE_BITS-1:0] read_data;
        bit                 glyph_done;
    } blit_res_t;

    typedef struct {
        blit_txn_t txn;
        bit        typed;
        blit_res_t res;
    } blit_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    glyph_blit_page_framebuffer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bit [BYTE_BITS-1:0] frame_img [STORE_BYTES];
    int                 g_row;
    int                 g_col;
    bit [ROTATION_W-1:0] rot_cfg;
    blit_res_t          pending_results [$];
    blit_row_t          directed_rows [$];

    int mismatches;
    int n_items;
    int n_results;
    int n_reads;
    int n_clears;
    int n_glyph_done;
    int n_rot_settings;
    int idle_cycles;
    int burst_left;
    int rcv_left;
    bit [15:0] stall_pat;

    function automatic void plot_pixel(int x, int y, bit [COLOUR_W-1:0] col);
        int lw;
        int lh;
        int px;
        int py;
        int addr;
        bit [BYTE_BITS-1:0] mask;
        bit [ADDR_W-1:0] ai;
        lw = rot_cfg[0] ? DISPLAY_HEIGHT : DISPLAY_WIDTH;
        lh = rot_cfg[0] ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
        if (x < 0 || x >= lw || y < 0 || y >= lh) return;
        case (rot_cfg)
            2'd1: begin
                px = DISPLAY_WIDTH - 1 - y;
                py = x;
            end
            2'd2: begin
                px = DISPLAY_WIDTH - 1 - x;
                py = DISPLAY_HEIGHT - 1 - y;
            end
            2'd3: begin
                px = y;
                py = DISPLAY_HEIGHT - 1 - x;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        addr = px + (py / PAGE_ROWS) * DISPLAY_WIDTH;
        if (addr >= STORE_BYTES) return;
        ai = ADDR_W'(addr);
        mask = 8'h01 << (py % PAGE_ROWS);
        case (col)
            COL_CLEAR:  frame_img[ai] = frame_img[ai] & ~mask;
            COL_SET:    frame_img[ai] = frame_img[ai] | mask;
            COL_INVERT: frame_img[ai] = frame_img[ai] ^ mask;
            default: ;
        endcase
    endfunction

    function automatic bit glyph_step(blit_txn_t t);
        int x0;
        int y0;
        int w;
        int h;
        int n;
        int k;
        x0 = int'(t.pos_x);
        y0 = int'(t.pos_y);
        w = int'(t.gw);
        h = int'(t.gh);
        if (w > MAX_GLYPH) w = MAX_GLYPH;
        if (h > MAX_GLYPH) h = MAX_GLYPH;
        if (t.start) begin
            g_row = 0;
            g_col = 0;
        end
        if (w == 0 || h == 0) begin
            g_row = 0;
            g_col = 0;
            return 1'b1;
        end
        if (g_col >= w) begin
            g_col = 0;
            g_row++;
        end
        if (g_row >= h) begin
            g_row = 0;
            g_col = 0;
            return 1'b1;
        end
        n = w - g_col;
        if (n > PAGE_ROWS) n = PAGE_ROWS;
        for (k = 0; k < n; k++) begin
            if (t.bitmap[KIDX_W'(BYTE_BITS - 1 - k)])
                plot_pixel(x0 + g_col + k, y0 + g_row, t.colour);
            else if (t.bg_colour != t.colour)
                plot_pixel(x0 + g_col + k, y0 + g_row, t.bg_colour);
        end
        g_col += n;
        if (g_col >= w) begin
            g_col = 0;
            g_row++;
            if (g_row >= h) begin
                g_row = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic blit_res_t blit_result(blit_txn_t t);
        blit_res_t r;
        r.read_data = '0;
        r.glyph_done = 1'b0;
        case (t.func)
            FUNC_PLOT:  plot_pixel(int'(t.pos_x), int'(t.pos_y), t.colour);
            FUNC_GLYPH: r.glyph_done = glyph_step(t);
            FUNC_CLEAR: foreach (frame_img[a]) frame_img[a] = '0;
            default: begin
                if (t.raddr < STORE_BYTES) r.read_data = frame_img[t.raddr];
            end
        endcase
        return r;
    endfunction

    function automatic blit_txn_t mk(bit [FUNC_W-1:0] f, int x, int y, bit [COLOUR_W-1:0] c,
                                     bit [COLOUR_W-1:0] bg, int w, int h,
                                     bit [BYTE_BITS-1:0] bits, bit st, int ra);
        blit_txn_t t;
        t.func = f;
        t.pos_x = POS_W'(x);
        t.pos_y = POS_W'(y);
        t.colour = c;
        t.bg_colour = bg;
        t.gw = GSIZE_W'(w);
        t.gh = GSIZE_W'(h);
        t.bitmap = bits;
        t.start = st;
        t.raddr = RADDR_IN_W'(ra);
        return t;
    endfunction

    function automatic blit_txn_t rand_txn();
        blit_txn_t t;
        t.func = FUNC_W'($urandom);
        t.pos_x = POS_W'($urandom);
        t.pos_y = POS_W'($urandom);
        t.colour = COLOUR_W'($urandom);
        t.bg_colour = COLOUR_W'($urandom);
        t.gw = GSIZE_W'($urandom);
        t.gh = GSIZE_W'($urandom);
        t.bitmap = BYTE_BITS'($urandom);
        t.start = 1'($urandom);
        t.raddr = RADDR_IN_W'($urandom);
        return t;
    endfunction

    task automatic add_row(blit_txn_t t, bit typed, bit [BYTE_BITS-1:0] d, bit dn);
        blit_row_t row;
        row.txn = t;
        row.typed = typed;
        row.res.read_data = d;
        row.res.glyph_done = dn;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic send_txn(blit_txn_t t, bit typed, blit_res_t typed_res);
        blit_res_t r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tdata = '0;
        s_tdata[POS_X_LSB +: POS_W] = t.pos_x;
        s_tdata[POS_Y_LSB +: POS_W] = t.pos_y;
        s_tdata[COLOUR_LSB +: COLOUR_W] = t.colour;
        s_tdata[BG_LSB +: COLOUR_W] = t.bg_colour;
        s_tdata[GW_LSB +: GSIZE_W] = t.gw;
        s_tdata[GH_LSB +: GSIZE_W] = t.gh;
        s_tdata[BITMAP_LSB +: BYTE_BITS] = t.bitmap;
        s_tdata[RADDR_LSB +: RADDR_IN_W] = t.raddr;
        s_tuser = '0;
        s_tuser[FUNC_LSB +: FUNC_W] = t.func;
        s_tuser[START_LSB] = t.start;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = blit_result(t);
        if (typed) r = typed_res;
        pending_results.push_back(r);
        n_items++;
        if (t.func == FUNC_READ) n_reads++;
        if (t.func == FUNC_CLEAR) n_clears++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, bit [PADDR_W-1:0] a, bit [PDATA_W-1:0] d);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = a;
        pwdata = d;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr && a == ROT_ADDR) rot_cfg = d[ROTATION_W-1:0];
        if (!wr && prdata !== PDATA_W'(rot_cfg))
            report_mismatch($sformatf("rotation readback expected %0h got %0h", rot_cfg, prdata));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_rotation(bit [ROTATION_W-1:0] r);
        bit [PDATA_W-1:0] wd;
        wd = $urandom;
        wd[ROTATION_W-1:0] = r;
        apb_access(1'b1, ROT_ADDR, wd);
        apb_access(1'b0, ROT_ADDR, '0);
        n_rot_settings++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        rcv_left = 0;
        stall_pat = '1;
        forever begin
            @(negedge aclk);
            if (rcv_left == 0) begin
                rcv_left = $urandom_range(50, 300);
                case ($urandom_range(0, 2))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom) | 16'($urandom) | 16'h0001;
                endcase
            end
            rcv_left--;
            m_tready = stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge aclk) begin : result_check
        blit_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tlast) n_glyph_done++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%0h last=%0b",
                                          m_tdata, m_tlast));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.read_data || m_tlast !== want.glyph_done)
                    report_mismatch($sformatf("result %0d: expected data=%0h last=%0b, got data=%0h last=%0b",
                                              n_results, want.read_data, want.glyph_done,
                                              m_tdata, m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: no transaction for %0d cycles, %0d results pending.",
                     idle_cycles, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        blit_txn_t t;
        blit_res_t no_res;
        int ph;
        int cnt;
        int sel;
        int lw;
        int lh;
        int wv;
        int hv;
        int total;
        int i;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_res.read_data = '0;
        no_res.glyph_done = 1'b0;
        g_row = 0;
        g_col = 0;
        rot_cfg = '0;
        idle_cycles = 0;
        burst_left = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        set_rotation(2'd0);

        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 0), 1, 8'h00, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 1023), 1, 8'h00, 0);
        add_row(mk(FUNC_PLOT, 0, 0, COL_SET, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 0), 1, 8'h01, 0);
        add_row(mk(FUNC_PLOT, 127, 63, COL_SET, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 1023), 1, 8'h80, 0);
        add_row(mk(FUNC_PLOT, -1, 0, COL_SET, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_PLOT, 128, 5, COL_SET, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_PLOT, 5, 64, COL_SET, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_PLOT, -32768, 32767, COL_SET, COL_SET, 127, 127, 8'hFF, 1, 1023),
                0, 0, 0);
        add_row(mk(FUNC_PLOT, 32767, -32768, COL_INVERT, COL_KEEP, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_PLOT, 0, 0, COL_INVERT, COL_CLEAR, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 0), 1, 8'h00, 0);
        add_row(mk(FUNC_PLOT, 3, 9, COL_KEEP, COL_SET, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 131), 1, 8'h00, 0);
        add_row(mk(FUNC_GLYPH, 10, 10, COL_SET, COL_CLEAR, 0, 5, 8'hFF, 1, 0), 1, 8'h00, 1);
        add_row(mk(FUNC_GLYPH, 10, 10, COL_SET, COL_CLEAR, 9, 2, 8'hFF, 1, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 10, 10, COL_SET, COL_CLEAR, 9, 2, 8'h80, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 10, 10, COL_SET, COL_CLEAR, 9, 2, 8'hAA, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 10, 10, COL_SET, COL_CLEAR, 9, 2, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 120, 60, COL_INVERT, COL_KEEP, 127, 127, 8'h5A, 1, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 120, 60, COL_INVERT, COL_KEEP, 8, 1, 8'hFF, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_GLYPH, 20, 30, COL_SET, COL_SET, 3, 1, 8'h40, 1, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 138), 0, 0, 0);
        add_row(mk(FUNC_CLEAR, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 0), 0, 0, 0);
        add_row(mk(FUNC_READ, 0, 0, COL_SET, COL_SET, 0, 0, 8'h00, 0, 138), 1, 8'h00, 0);

        foreach (directed_rows[r])
            send_txn(directed_rows[r].txn, directed_rows[r].typed, directed_rows[r].res);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            set_rotation(ROTATION_W'((ph * 3 + 3) % 4));
            lw = rot_cfg[0] ? DISPLAY_HEIGHT : DISPLAY_WIDTH;
            lh = rot_cfg[0] ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                t = rand_txn();
                if (sel < 2) begin
                    t.func = FUNC_CLEAR;
                    send_txn(t, 0, no_res);
                    cnt++;
                end else if (sel < 30) begin
                    t.func = FUNC_PLOT;
                    if ($urandom_range(0, 3) != 0) begin
                        t.pos_x = POS_W'($urandom_range(0, lw + 5) - 3);
                        t.pos_y = POS_W'($urandom_range(0, lh + 5) - 3);
                    end
                    send_txn(t, 0, no_res);
                    cnt++;
                end else if (sel < 55) begin
                    t.func = FUNC_READ;
                    send_txn(t, 0, no_res);
                    cnt++;
                end else if (sel < 92) begin
                    // A glyph is a run of bitmap bytes that usually begins with the start flag.
                    t.func = FUNC_GLYPH;
                    sel = $urandom_range(0, 99);
                    wv = (sel < 4) ? 0 : (sel < 12) ? $urandom_range(65, 127)
                                                    : $urandom_range(1, 24);
                    sel = $urandom_range(0, 99);
                    hv = (sel < 4) ? 0 : (sel < 8) ? $urandom_range(65, 127)
                                                   : $urandom_range(1, 12);
                    t.gw = GSIZE_W'(wv);
                    t.gh = GSIZE_W'(hv);
                    if (wv > MAX_GLYPH) wv = MAX_GLYPH;
                    if (hv > MAX_GLYPH) hv = MAX_GLYPH;
                    total = ((wv + 7) / 8) * hv;
                    if (total == 0) total = 1;
                    if (total > 96) total = $urandom_range(8, 96);
                    if ($urandom_range(0, 9) == 0) total = $urandom_range(1, total);
                    if ($urandom_range(0, 9) != 0) begin
                        t.pos_x = POS_W'($urandom_range(0, lw + 20) - 10);
                        t.pos_y = POS_W'($urandom_range(0, lh + 20) - 10);
                    end
                    if ($urandom_range(0, 2) == 0) t.bg_colour = t.colour;
                    t.start = ($urandom_range(0, 19) != 0);
                    for (i = 0; i < total; i++) begin
                        t.bitmap = BYTE_BITS'($urandom);
                        if (i > 0) t.start = 1'b0;
                        if (i > 0 && $urandom_range(0, 39) == 0)
                            t.gw = GSIZE_W'($urandom_range(0, 20));
                        if (i > 0 && $urandom_range(0, 59) == 0)
                            t.gh = GSIZE_W'($urandom_range(0, 12));
                        send_txn(t, 0, no_res);
                        cnt++;
                    end
                end else begin
                    t.func = FUNC_GLYPH;
                    send_txn(t, 0, no_res);
                    cnt++;
                end
            end
        end

        wait_drained();
        $display("Ran %0d transactions (%0d reads, %0d clears) and checked %0d results,",
                 n_items, n_reads, n_clears, n_results);
        $display("with %0d completed glyphs over %0d rotation settings; %0d mismatches.",
                 n_glyph_done, n_rot_settings, mismatches);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived.", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
